// ===== rtl/core/cst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and constants for the counting semaphore table.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int NUM_SLOTS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam logic [15:0] AUTO_ID_BASE = 16'd10;

  // request codes
  localparam logic [2:0] REQ_CREATE = 3'd0;
  localparam logic [2:0] REQ_WAIT   = 3'd1;
  localparam logic [2:0] REQ_SIGNAL = 3'd2;
  localparam logic [2:0] REQ_REMOVE = 3'd3;
  localparam logic [2:0] REQ_AUTO   = 3'd4;

  // status codes
  localparam logic [2:0] ST_DONE       = 3'd0;
  localparam logic [2:0] ST_BLOCKED    = 3'd1;
  localparam logic [2:0] ST_BAD_ID     = 3'd2;
  localparam logic [2:0] ST_NO_SLOT    = 3'd3;
  localparam logic [2:0] ST_QUEUE_FULL = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_AUTO,
    S_WTAKE,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] new_id;
    logic        woken_valid;
    logic [15:0] woken_pid;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/core/cst_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/cst_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cst_ctrl
// Request sequencer: scans the slot RAM (error requests skip it), then
// reads/modifies/writes the slot entry and the waiter RAM for one request.
// ----------------------------------------------------------------------------
module cst_ctrl #(
  parameter int NUM_SLOTS   = cst_pkg::NUM_SLOTS_DEF,
  parameter int QUEUE_DEPTH = cst_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire logic [2:0]    req_type,
  input  wire logic [15:0]   req_id,
  input  wire logic [15:0]   req_init,
  input  wire logic [15:0]   req_pid,
  output logic               res_valid,
  input  wire logic          res_take,
  output cst_pkg::res_t      res
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int UW = $clog2(NUM_SLOTS + 1);
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int LW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = 32 + 2 * PW + LW;
  localparam int WD = NUM_SLOTS * QUEUE_DEPTH;
  localparam int WA = $clog2(WD);

  cst_pkg::state_t state_r, state_nxt;

  logic [2:0]           req_r, req_nxt;
  logic [15:0]          id_r, id_nxt;
  logic [15:0]          init_r, init_nxt;
  logic [15:0]          pid_r, pid_nxt;
  logic [IW-1:0]        rd_idx_r, rd_idx_nxt;
  logic                 rd_done_r, rd_done_nxt;
  logic                 chk_v_r, chk_v_nxt;
  logic [IW-1:0]        chk_idx_r, chk_idx_nxt;
  logic                 match_r, match_nxt;
  logic [IW-1:0]        m_idx_r, m_idx_nxt;
  logic [15:0]          m_val_r, m_val_nxt;
  logic [PW-1:0]        m_head_r, m_head_nxt;
  logic [PW-1:0]        m_tail_r, m_tail_nxt;
  logic [LW-1:0]        m_len_r, m_len_nxt;
  logic                 free_found_r, free_found_nxt;
  logic [IW-1:0]        free_idx_r, free_idx_nxt;
  logic [NUM_SLOTS-1:0] bitmap_r, bitmap_nxt;
  logic [IW-1:0]        k_r, k_nxt;
  logic [UW-1:0]        used_r, used_nxt;
  logic [NUM_SLOTS-1:0] valid_r, valid_nxt;
  cst_pkg::res_t        res_r, res_nxt;

  // slot RAM
  logic          sl_we;
  logic [IW-1:0] sl_waddr;
  logic [SW-1:0] sl_wdata;
  logic [SW-1:0] sl_rdata;

  // waiter RAM
  logic          wq_we;
  logic [WA-1:0] wq_waddr;
  logic [WA-1:0] wq_raddr;
  logic [15:0]   wq_rdata;

  cst_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (sl_we),
    .waddr (sl_waddr),
    .wdata (sl_wdata),
    .raddr (rd_idx_r),
    .rdata (sl_rdata)
  );

  cst_ram #(.WIDTH(16), .DEPTH(WD)) u_waiter_ram (
    .clk   (clk),
    .we    (wq_we),
    .waddr (wq_waddr),
    .wdata (pid_r),
    .raddr (wq_raddr),
    .rdata (wq_rdata)
  );

  // entry fields; a free slot reads as all zero
  logic [SW-1:0] ent;
  logic [15:0]   e_ident, e_val;
  logic [PW-1:0] e_head, e_tail;
  logic [LW-1:0] e_len;
  logic [15:0]   id_off;

  assign ent     = valid_r[chk_idx_r] ? sl_rdata : '0;
  assign e_ident = ent[SW-1 -: 16];
  assign e_val   = ent[SW-17 -: 16];
  assign e_head  = ent[2*PW+LW-1 -: PW];
  assign e_tail  = ent[PW+LW-1 -: PW];
  assign e_len   = ent[LW-1:0];
  assign id_off  = e_ident - cst_pkg::AUTO_ID_BASE;

  logic full;
  assign full = (used_r == UW'(NUM_SLOTS));

  // requests answered without a table scan
  logic       quick;
  logic [2:0] quick_st;
  always_comb begin
    quick    = 1'b1;
    quick_st = cst_pkg::ST_BAD_ID;
    unique case (req_type)
      cst_pkg::REQ_CREATE: begin
        if (req_id == 16'd0) begin
          quick_st = cst_pkg::ST_BAD_ID;
        end else if (full) begin
          quick_st = cst_pkg::ST_NO_SLOT;
        end else begin
          quick = 1'b0;
        end
      end
      cst_pkg::REQ_AUTO: begin
        if (full) begin
          quick_st = cst_pkg::ST_NO_SLOT;
        end else begin
          quick = 1'b0;
        end
      end
      cst_pkg::REQ_WAIT, cst_pkg::REQ_SIGNAL, cst_pkg::REQ_REMOVE: begin
        quick = (req_id == 16'd0);
      end
      default: quick = 1'b1;
    endcase
  end

  logic accept;
  logic last_chk;
  logic pend_wake;
  assign accept    = (state_r == cst_pkg::S_IDLE) && req_valid;
  assign last_chk  = chk_v_r && (chk_idx_r == IW'(NUM_SLOTS - 1));
  assign pend_wake = match_r && (m_len_r != '0);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cst_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = quick ? cst_pkg::S_FIN : cst_pkg::S_SCAN;
        end
      end
      cst_pkg::S_SCAN: begin
        if (last_chk) begin
          state_nxt = cst_pkg::S_DECIDE;
        end
      end
      cst_pkg::S_DECIDE: begin
        if (req_r == cst_pkg::REQ_AUTO) begin
          state_nxt = cst_pkg::S_AUTO;
        end else if (req_r == cst_pkg::REQ_SIGNAL && pend_wake) begin
          state_nxt = cst_pkg::S_WTAKE;
        end else begin
          state_nxt = cst_pkg::S_FIN;
        end
      end
      cst_pkg::S_AUTO: begin
        if (!bitmap_r[k_r]) begin
          state_nxt = cst_pkg::S_FIN;
        end
      end
      cst_pkg::S_WTAKE: state_nxt = cst_pkg::S_FIN;
      cst_pkg::S_FIN: begin
        if (res_take) begin
          state_nxt = cst_pkg::S_IDLE;
        end
      end
      default: state_nxt = cst_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_nxt        = req_r;
    id_nxt         = id_r;
    init_nxt       = init_r;
    pid_nxt        = pid_r;
    rd_idx_nxt     = rd_idx_r;
    rd_done_nxt    = rd_done_r;
    chk_v_nxt      = 1'b0;
    chk_idx_nxt    = rd_idx_r;
    match_nxt      = match_r;
    m_idx_nxt      = m_idx_r;
    m_val_nxt      = m_val_r;
    m_head_nxt     = m_head_r;
    m_tail_nxt     = m_tail_r;
    m_len_nxt      = m_len_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    bitmap_nxt     = bitmap_r;
    k_nxt          = k_r;
    used_nxt       = used_r;
    valid_nxt      = valid_r;
    res_nxt        = res_r;
    sl_we          = 1'b0;
    sl_waddr       = m_idx_r;
    sl_wdata       = {id_r, m_val_r, m_head_r, m_tail_r, m_len_r};
    wq_we          = 1'b0;
    wq_waddr       = WA'(m_idx_r) * WA'(QUEUE_DEPTH) + WA'(m_tail_r);
    wq_raddr       = WA'(m_idx_r) * WA'(QUEUE_DEPTH) + WA'(m_head_r);

    unique case (state_r)
      cst_pkg::S_IDLE: begin
        if (accept) begin
          req_nxt        = req_type;
          id_nxt         = req_id;
          init_nxt       = req_init;
          pid_nxt        = req_pid;
          rd_idx_nxt     = '0;
          rd_done_nxt    = 1'b0;
          match_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          bitmap_nxt     = '0;
          k_nxt          = '0;
          res_nxt        = '0;
          res_nxt.status = quick_st;
        end
      end
      cst_pkg::S_SCAN: begin
        // issue one read a cycle, check the entry read the cycle before
        chk_v_nxt = !rd_done_r;
        if (!rd_done_r) begin
          if (rd_idx_r == IW'(NUM_SLOTS - 1)) begin
            rd_done_nxt = 1'b1;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end
        if (chk_v_r) begin
          if (e_ident == id_r && e_ident != 16'd0) begin
            match_nxt  = 1'b1;
            m_idx_nxt  = chk_idx_r;
            m_val_nxt  = e_val;
            m_head_nxt = e_head;
            m_tail_nxt = e_tail;
            m_len_nxt  = e_len;
          end
          if (e_ident == 16'd0 && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = chk_idx_r;
          end
          if (e_ident >= cst_pkg::AUTO_ID_BASE && id_off < 16'(NUM_SLOTS)) begin
            bitmap_nxt[id_off[IW-1:0]] = 1'b1;
          end
        end
      end
      cst_pkg::S_DECIDE: begin
        res_nxt.status = cst_pkg::ST_DONE;
        unique case (req_r)
          cst_pkg::REQ_CREATE: begin
            if (match_r) begin
              res_nxt.status = cst_pkg::ST_BAD_ID;
            end else begin
              sl_we                  = 1'b1;
              sl_waddr               = free_idx_r;
              sl_wdata               = {id_r, init_r, {(SW - 32){1'b0}}};
              valid_nxt[free_idx_r]  = 1'b1;
              used_nxt               = used_r + 1'b1;
              res_nxt.new_id         = id_r;
            end
          end
          cst_pkg::REQ_WAIT: begin
            if (!match_r) begin
              res_nxt.status = cst_pkg::ST_BAD_ID;
            end else if (m_val_r != 16'd0) begin
              sl_we    = 1'b1;
              sl_wdata = {id_r, m_val_r - 16'd1, m_head_r, m_tail_r, m_len_r};
            end else if (m_len_r == LW'(QUEUE_DEPTH)) begin
              res_nxt.status = cst_pkg::ST_QUEUE_FULL;
            end else begin
              wq_we          = 1'b1;
              sl_we          = 1'b1;
              sl_wdata       = {id_r, m_val_r, m_head_r, ptr_inc(m_tail_r),
                                m_len_r + 1'b1};
              res_nxt.status = cst_pkg::ST_BLOCKED;
            end
          end
          cst_pkg::REQ_SIGNAL: begin
            if (!match_r) begin
              res_nxt.status = cst_pkg::ST_BAD_ID;
            end else if (!pend_wake && m_val_r != 16'hFFFF) begin
              sl_we    = 1'b1;
              sl_wdata = {id_r, m_val_r + 16'd1, m_head_r, m_tail_r, m_len_r};
            end
          end
          cst_pkg::REQ_REMOVE: begin
            if (!match_r) begin
              res_nxt.status = cst_pkg::ST_BAD_ID;
            end else begin
              valid_nxt[m_idx_r] = 1'b0;
              used_nxt           = used_r - 1'b1;
            end
          end
          default: res_nxt.status = cst_pkg::ST_DONE;
        endcase
      end
      cst_pkg::S_AUTO: begin
        // walk the taken-id bitmap for the lowest free id
        if (!bitmap_r[k_r]) begin
          sl_we                 = 1'b1;
          sl_waddr              = free_idx_r;
          sl_wdata              = {cst_pkg::AUTO_ID_BASE + 16'(k_r), init_r,
                                   {(SW - 32){1'b0}}};
          valid_nxt[free_idx_r] = 1'b1;
          used_nxt              = used_r + 1'b1;
          res_nxt.new_id        = cst_pkg::AUTO_ID_BASE + 16'(k_r);
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      cst_pkg::S_WTAKE: begin
        sl_we               = 1'b1;
        sl_wdata            = {id_r, m_val_r, ptr_inc(m_head_r), m_tail_r,
                               m_len_r - 1'b1};
        res_nxt.woken_valid = 1'b1;
        res_nxt.woken_pid   = wq_rdata;
      end
      cst_pkg::S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cst_pkg::S_IDLE;
      used_r  <= '0;
      valid_r <= '0;
      chk_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      valid_r <= valid_nxt;
      chk_v_r <= chk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    id_r         <= id_nxt;
    init_r       <= init_nxt;
    pid_r        <= pid_nxt;
    rd_idx_r     <= rd_idx_nxt;
    rd_done_r    <= rd_done_nxt;
    chk_idx_r    <= chk_idx_nxt;
    match_r      <= match_nxt;
    m_idx_r      <= m_idx_nxt;
    m_val_r      <= m_val_nxt;
    m_head_r     <= m_head_nxt;
    m_tail_r     <= m_tail_nxt;
    m_len_r      <= m_len_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    bitmap_r     <= bitmap_nxt;
    k_r          <= k_nxt;
    res_r        <= res_nxt;
  end

  assign req_stall = (state_r != cst_pkg::S_IDLE);
  assign res_valid = (state_r == cst_pkg::S_FIN);
  assign res       = res_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(NUM_SLOTS))
    else $error("used-slot count above table size");

  a_used_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_r) == $countones(valid_r))
    else $error("used-slot count out of step with valid bits");

  a_wq_write_live_slot: assert property (@(posedge clk) disable iff (!rst_n)
    wq_we |-> valid_r[m_idx_r] && m_len_r != LW'(QUEUE_DEPTH))
    else $error("waiter write into free slot or full queue");

endmodule
`default_nettype wire

// ===== rtl/core/counting_semaphore_table.sv =====
`default_nettype none
// Error requests (id zero, table full, bad type) go straight to the result
//   state; others first scan the slot RAM, then take an extra state for a
//   wake-up or a bitmap walk for an automatic id. Throughput: one request at a
//   time, bounded by the slot-RAM scan (one entry read per cycle).
// Reset: rst_n synchronous; all slots free, no result pending. Waiter RAM is
//   not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
// counting_semaphore_table
// Table of counting semaphores with FIFO wait queues, one result beat per
// request beat.
// ----------------------------------------------------------------------------
module counting_semaphore_table #(
  parameter int NUM_SLOTS   = cst_pkg::NUM_SLOTS_DEF,
  parameter int QUEUE_DEPTH = cst_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [15:0] in_sem_id,
  input  wire logic [15:0] in_init_value,
  input  wire logic [15:0] in_pid,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [15:0]      out_new_id,
  output logic             out_woken_valid,
  output logic [15:0]      out_woken_pid
);

  logic          res_valid;
  logic          res_take;
  cst_pkg::res_t res;

  logic          out_valid_r, out_valid_nxt;
  cst_pkg::res_t out_r, out_nxt;

  cst_ctrl #(
    .NUM_SLOTS   (NUM_SLOTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_stall (in_stall),
    .req_type  (in_req_type),
    .req_id    (in_sem_id),
    .req_init  (in_init_value),
    .req_pid   (in_pid),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // output register: refills when empty or being drained
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_take) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_new_id      = out_r.new_id;
  assign out_woken_valid = out_r.woken_valid;
  assign out_woken_pid   = out_r.woken_pid;

endmodule
`default_nettype wire
